// ----- rtl/core/b64enc_pkg.sv -----
// shared types and the base64 alphabet lookup for the stream encoder
`timescale 1ns / 1ps

package b64enc_pkg;

  localparam int CHAR_W = 7;
  localparam int SEXTET_W = 6;
  localparam logic [CHAR_W-1:0] PAD_RESET = 7'd37;

  typedef struct packed {
    logic [SEXTET_W-1:0] s0;
    logic [SEXTET_W-1:0] s1;
    logic                two_chars;
    logic [1:0]          pad_cnt;
    logic                last;
  } job_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] vx;
    logic [CHAR_W-1:0] ch;
    vx = {1'b0, v};
    case (v) inside
      [6'd0:6'd25]:  ch = vx + 7'd65;
      [6'd26:6'd51]: ch = vx + 7'd71;
      [6'd52:6'd61]: ch = vx - 7'd4;
      6'd62:         ch = 7'd43;
      default:       ch = 7'd47;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/b64enc_front.sv -----
// front end: accepts bytes, tracks group position and builds character jobs
`timescale 1ns / 1ps

module b64enc_front import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [1:0] group_phase;
  logic [1:0] group_phase_next;
  logic [3:0] carry_bits;
  logic [3:0] carry_bits_next;

  assign in_ready = !q_full;
  assign q_push = in_valid && in_ready;

  always_comb begin
    q_job = '0;
    q_job.last = last_byte;
    group_phase_next = 2'd0;
    carry_bits_next = 4'd0;
    case (group_phase)
      2'd1: begin
        q_job.s0 = {carry_bits[1:0], data_byte[7:4]};
        q_job.s1 = {data_byte[3:0], 2'b00};
        q_job.two_chars = last_byte;
        q_job.pad_cnt = last_byte ? 2'd1 : 2'd0;
        if (!last_byte) begin
          group_phase_next = 2'd2;
          carry_bits_next = data_byte[3:0];
        end
      end
      2'd2: begin
        q_job.s0 = {carry_bits, data_byte[7:6]};
        q_job.s1 = data_byte[5:0];
        q_job.two_chars = 1'b1;
        q_job.pad_cnt = 2'd0;
      end
      default: begin
        q_job.s0 = data_byte[7:2];
        q_job.s1 = {data_byte[1:0], 4'b0000};
        q_job.two_chars = last_byte;
        q_job.pad_cnt = last_byte ? 2'd2 : 2'd0;
        if (!last_byte) begin
          group_phase_next = 2'd1;
          carry_bits_next = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= 2'd0;
      carry_bits <= 4'd0;
    end else if (q_push) begin
      group_phase <= group_phase_next;
      carry_bits <= carry_bits_next;
    end
  end

endmodule

// ----- rtl/core/b64enc_queue.sv -----
// two-entry job queue between front and back
`timescale 1ns / 1ps

module b64enc_queue import b64enc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/b64enc_back.sv -----
// back end: emits the characters of each job through an output register
`timescale 1ns / 1ps

module b64enc_back import b64enc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  input  logic              q_not_empty,
  input  job_t              q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic [CHAR_W-1:0] pad_char;
  logic [1:0]        step;
  logic [1:0]        final_step;
  logic              is_final;
  logic              load;
  logic [CHAR_W-1:0] char_next;

  assign final_step = {1'b0, q_head.two_chars} + q_head.pad_cnt;
  assign is_final = (step == final_step);
  assign load = q_not_empty && (!out_valid || out_ready);
  assign q_pop = load && is_final;

  always_comb begin
    if (step == 2'd0) begin
      char_next = sextet_char(q_head.s0);
    end else if (step == 2'd1 && q_head.two_chars) begin
      char_next = sextet_char(q_head.s1);
    end else begin
      char_next = pad_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_char <= PAD_RESET;
    end else if (cfg_we) begin
      pad_char <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step <= is_final ? 2'd0 : step + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      out_last <= is_final && q_head.last;
    end
  end

endmodule

// ----- rtl/core/base64_stream_encoder.sv -----
// top level of the streaming base64 encoder
`timescale 1ns / 1ps

// Streaming base64 encoder: one raw byte per input transaction, one character
// per output transaction. A byte yields one character, or two when it closes a
// group of three; a byte marked last also flushes the group with padding
// (pad_char, reset value '%') and marks the final character with out_last.
// The output side emits one character per cycle while out_ready is high; a
// full group of three bytes gives four characters, a last byte up to four.
// Input accepts a byte every cycle while the two-entry job queue has room.

module base64_stream_encoder import b64enc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic q_not_empty;
  job_t q_head;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  b64enc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_last    (out_last)
  );

endmodule
